// ===== rtl/core/rcd_pkg.sv =====
// Package for the record cache deserializer: field widths, parse phase codes,
// configuration register indexes and the item and result structs.
// No dependencies.
package rcd_pkg;

    localparam int unsigned HdrLen     = 7;
    localparam int unsigned RecLen     = 9;
    localparam int unsigned LenWidth   = 20;
    localparam int unsigned CountWidth = 16;
    localparam int unsigned MacWidth   = 64;
    localparam int unsigned CfgWidth   = 32;
    localparam int unsigned CfgIdxW    = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAGIC    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_VERSION  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CLASSLIM = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 2'd3;

    // Parse phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_RECORDS = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                first_byte;
        logic [LenWidth-1:0] buffer_length;
    } t_item;

    typedef struct packed {
        logic                  record_valid;
        logic                  finished;
        logic                  success;
        logic [MacWidth-1:0]   mac_address;
        logic [7:0]            class_code;
        logic [CountWidth-1:0] accepted_count;
    } t_result;

endpackage

// ===== rtl/core/rcd_if.sv =====
// Stream interfaces for the record cache deserializer: byte input channel
// and result channel. Depends on rcd_pkg.
interface rcd_in_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 data_byte;
    logic                       first_byte;
    logic [rcd_pkg::LenWidth-1:0] buffer_length;

    modport source (output valid, data_byte, first_byte, buffer_length, input ready);
    modport sink   (input valid, data_byte, first_byte, buffer_length, output ready);
endinterface

interface rcd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           record_valid;
    logic                           finished;
    logic                           success;
    logic [rcd_pkg::MacWidth-1:0]   mac_address;
    logic [7:0]                     class_code;
    logic [rcd_pkg::CountWidth-1:0] accepted_count;

    modport source (output valid, record_valid, finished, success, mac_address,
                    class_code, accepted_count, input ready);
    modport sink   (input valid, record_valid, finished, success, mac_address,
                    class_code, accepted_count, output ready);
endinterface

// ===== rtl/core/rcd_parser.sv =====
// Parse state and configuration registers of the record cache deserializer.
// Decodes one accepted byte per cycle into at most one result. Uses rcd_pkg.
module rcd_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcd_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [rcd_pkg::CfgWidth-1:0]    i_cfg_data,
    input  logic                            i_accept,
    input  rcd_pkg::t_item                  i_item,
    output logic                            o_res_valid,
    output rcd_pkg::t_result                o_res
);
    import rcd_pkg::*;

    logic [31:0]           r_magic;
    logic [7:0]            r_version;
    logic [8:0]            r_class_limit;
    logic [CountWidth-1:0] r_capacity;

    logic [1:0]            r_phase,    n_phase;
    logic [3:0]            r_pos,      n_pos;
    logic [MacWidth-1:0]   r_asm,      n_asm;
    logic [CountWidth-1:0] r_hdr_cnt,  n_hdr_cnt;
    logic [CountWidth-1:0] r_rd,       n_rd;
    logic [CountWidth-1:0] r_acc,      n_acc;
    logic [LenWidth-1:0]   r_len,      n_len;

    logic [LenWidth:0]     need_len;
    logic [CountWidth-1:0] full_cnt;
    logic                  keep;
    logic                  last;
    logic [3:0]            pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic       <= '0;
            r_version     <= '0;
            r_class_limit <= 9'd256;
            r_capacity    <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:    r_magic       <= i_cfg_data;
                CFG_VERSION:  r_version     <= i_cfg_data[7:0];
                CFG_CLASSLIM: r_class_limit <= i_cfg_data[8:0];
                CFG_CAPACITY: r_capacity    <= i_cfg_data[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    assign full_cnt = {i_item.data_byte, r_hdr_cnt[7:0]};
    // 7 + 9 * count, at most 589822
    assign need_len = (LenWidth+1)'(HdrLen) + {1'b0, 1'b0, full_cnt, 3'b000}
                      + {5'b0, full_cnt};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_asm       = r_asm;
        n_hdr_cnt   = r_hdr_cnt;
        n_rd        = r_rd;
        n_acc       = r_acc;
        n_len       = r_len;
        o_res_valid = 1'b0;
        o_res       = '0;
        keep        = 1'b0;
        last        = 1'b0;
        pos         = r_pos;

        if (i_accept) begin
            if (i_item.first_byte) begin
                n_len     = i_item.buffer_length;
                n_phase   = PH_HEADER;
                n_pos     = '0;
                n_asm     = '0;
                n_hdr_cnt = '0;
                n_rd      = '0;
                n_acc     = '0;
                pos       = '0;
            end

            if (i_item.first_byte && i_item.buffer_length < LenWidth'(HdrLen)) begin
                n_phase           = PH_DONE;
                o_res_valid       = 1'b1;
                o_res.finished    = 1'b1;
            end else if (n_phase == PH_HEADER) begin
                n_pos = pos + 4'd1;
                if (pos < 4'd4) begin
                    n_asm[{pos[1:0], 3'b000} +: 8] = i_item.data_byte;
                    if (pos == 4'd3 && {i_item.data_byte, n_asm[23:0]} != r_magic) begin
                        n_phase        = PH_DONE;
                        n_acc          = '0;
                        o_res_valid    = 1'b1;
                        o_res.finished = 1'b1;
                    end
                end else if (pos == 4'd4) begin
                    if (i_item.data_byte != r_version) begin
                        n_phase        = PH_DONE;
                        n_acc          = '0;
                        o_res_valid    = 1'b1;
                        o_res.finished = 1'b1;
                    end
                end else if (pos == 4'd5) begin
                    n_hdr_cnt = {8'd0, i_item.data_byte};
                end else begin
                    n_hdr_cnt = full_cnt;
                    n_pos     = '0;
                    n_asm     = '0;
                    if ({1'b0, n_len} < need_len) begin
                        n_phase        = PH_DONE;
                        n_acc          = '0;
                        o_res_valid    = 1'b1;
                        o_res.finished = 1'b1;
                    end else if (full_cnt == '0 || r_capacity == '0) begin
                        n_phase        = PH_DONE;
                        o_res_valid    = 1'b1;
                        o_res.finished = 1'b1;
                        o_res.success  = 1'b1;
                    end else begin
                        n_phase = PH_RECORDS;
                    end
                end
            end else if (n_phase == PH_RECORDS) begin
                if (pos < 4'd8) begin
                    n_asm[{pos[2:0], 3'b000} +: 8] = i_item.data_byte;
                    n_pos = pos + 4'd1;
                end else begin
                    n_asm = '0;
                    n_pos = '0;
                    n_rd  = r_rd + 16'd1;
                    keep  = (r_asm != '0) && ({1'b0, i_item.data_byte} < r_class_limit);
                    if (keep) begin
                        n_acc = r_acc + 16'd1;
                    end
                    last = (n_rd >= r_hdr_cnt) || (n_acc >= r_capacity);
                    if (last) begin
                        n_phase = PH_DONE;
                    end
                    if (keep || last) begin
                        o_res_valid        = 1'b1;
                        o_res.record_valid = keep;
                        o_res.finished     = last;
                        o_res.success      = last;
                        o_res.mac_address  = keep ? r_asm : '0;
                        o_res.class_code   = keep ? i_item.data_byte : 8'd0;
                    end
                end
            end
            o_res.accepted_count = n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_asm     <= '0;
            r_hdr_cnt <= '0;
            r_rd      <= '0;
            r_acc     <= '0;
            r_len     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_asm     <= n_asm;
            r_hdr_cnt <= n_hdr_cnt;
            r_rd      <= n_rd;
            r_acc     <= n_acc;
            r_len     <= n_len;
        end
    end

    // a kept record always carries a nonzero address
    a_rec_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.record_valid |-> o_res.mac_address != '0)
        else $error("record emitted with zero address");

    // records are only ever read after a complete header
    a_rd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd != '0 |-> (r_phase == PH_RECORDS || r_phase == PH_DONE))
        else $error("records counted outside record phase");

    // accepted never runs ahead of read
    a_acc_le_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= r_rd)
        else $error("accepted count exceeds records read");

endmodule

// ===== rtl/core/record_cache_deserializer.sv =====
// Record cache deserializer, top level: parser plus a two-entry result
// buffer (output register and skid register). Uses rcd_pkg, rcd_in_if,
// rcd_out_if and rcd_parser.
//
// Usage: stream a stored buffer into i_in one byte per transaction, with
// first_byte set and buffer_length valid on its first byte. Results leave on
// o_out: one per kept record, plus a final one with finished set (success
// tells header or length failure apart from a normal end). A final record
// may carry record_valid and finished together. Configuration registers
// (magic, version, class limit, capacity) are written through i_cfg_* while
// no buffer is in flight.
// Each result is registered in the output register (or the skid register) before o_out.
// Throughput: one byte per cycle while i_in.ready is high; the parse state and
// the result register are the only stages, so the parse state loop sets that rate.
// Reset: synchronous, active low; parse returns to idle, registers take their
// defaults and both result entries empty.
// Stalls: while o_out.ready is low the skid register takes one more result;
// i_in.ready drops only once it is occupied.
module record_cache_deserializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rcd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [rcd_pkg::CfgWidth-1:0] i_cfg_data,
    rcd_in_if.sink                       i_in,
    rcd_out_if.source                    o_out
);
    import rcd_pkg::*;

    t_item   item;
    t_result res;
    logic    res_valid;
    logic    accept;
    logic    out_take;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    load_out_res;
    logic    load_out_skid;
    logic    load_skid;

    assign i_in.ready = !r_skid_valid;
    assign accept     = i_in.valid && i_in.ready;
    assign out_take   = r_out_valid && o_out.ready;

    assign item.data_byte     = i_in.data_byte;
    assign item.first_byte    = i_in.first_byte;
    assign item.buffer_length = i_in.buffer_length;

    rcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid   = r_out_valid;
        n_skid_valid  = r_skid_valid;
        load_out_res  = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (r_skid_valid) begin
            // no transaction accepted here: drain skid into output
            if (out_take) begin
                load_out_skid = 1'b1;
                n_skid_valid  = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                load_out_res = 1'b1;
                n_out_valid  = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_res) begin
            r_out <= res;
        end else if (load_out_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.record_valid   = r_out.record_valid;
    assign o_out.finished       = r_out.finished;
    assign o_out.success        = r_out.success;
    assign o_out.mac_address    = r_out.mac_address;
    assign o_out.class_code     = r_out.class_code;
    assign o_out.accepted_count = r_out.accepted_count;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with output register empty");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.finished |-> o_out.record_valid)
        else $error("result carries neither record nor end of parse");

    a_success_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.success |-> o_out.finished)
        else $error("success without finished");

    a_fail_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.finished && !o_out.success |-> o_out.accepted_count == '0)
        else $error("failed parse reports accepted records");

endmodule
